[rtl/core/jsc_pkg.sv]
package jsc_pkg;

	localparam int MaxDepthDef = 64;
	localparam int LineBitsDef = 32;

	localparam logic [4:0] P_VALUE      = 5'd0;
	localparam logic [4:0] P_ARR_FIRST  = 5'd1;
	localparam logic [4:0] P_OBJ_FIRST  = 5'd2;
	localparam logic [4:0] P_OBJ_KEY    = 5'd3;
	localparam logic [4:0] P_COLON      = 5'd4;
	localparam logic [4:0] P_STR        = 5'd5;
	localparam logic [4:0] P_ESC        = 5'd6;
	localparam logic [4:0] P_HEX        = 5'd7;
	localparam logic [4:0] P_LIT        = 5'd8;
	localparam logic [4:0] P_NUM_SIGN   = 5'd9;
	localparam logic [4:0] P_NUM_ZERO   = 5'd10;
	localparam logic [4:0] P_NUM_INT    = 5'd11;
	localparam logic [4:0] P_FRAC_FIRST = 5'd12;
	localparam logic [4:0] P_FRAC       = 5'd13;
	localparam logic [4:0] P_EXP_FIRST  = 5'd14;
	localparam logic [4:0] P_EXP_SIGNED = 5'd15;
	localparam logic [4:0] P_EXP        = 5'd16;
	localparam logic [4:0] P_AFTER      = 5'd17;

	localparam logic [4:0] E_NONE       = 5'd0;
	localparam logic [4:0] E_STRING     = 5'd1;
	localparam logic [4:0] E_CTRL       = 5'd2;
	localparam logic [4:0] E_ESC_END    = 5'd3;
	localparam logic [4:0] E_UNICODE    = 5'd4;
	localparam logic [4:0] E_ESCAPE     = 5'd5;
	localparam logic [4:0] E_UNTERM     = 5'd6;
	localparam logic [4:0] E_DIGIT      = 5'd7;
	localparam logic [4:0] E_LEAD_ZERO  = 5'd8;
	localparam logic [4:0] E_FRAC       = 5'd9;
	localparam logic [4:0] E_EXP        = 5'd10;
	localparam logic [4:0] E_LITERAL    = 5'd11;
	localparam logic [4:0] E_COLON      = 5'd12;
	localparam logic [4:0] E_ARR_SEP    = 5'd13;
	localparam logic [4:0] E_OBJ_SEP    = 5'd14;
	localparam logic [4:0] E_VALUE      = 5'd15;
	localparam logic [4:0] E_TRAILING   = 5'd16;
	localparam logic [4:0] E_DEEP       = 5'd17;

	localparam logic RES_RANGE   = 1'b0;
	localparam logic RES_VERDICT = 1'b1;

	// letters of true, false and null back to back
	function automatic logic [7:0] lit_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0: b = "t";
			4'd1: b = "r";
			4'd2: b = "u";
			4'd3: b = "e";
			4'd4: b = "f";
			4'd5: b = "a";
			4'd6: b = "l";
			4'd7: b = "s";
			4'd8: b = "e";
			4'd9: b = "n";
			4'd10: b = "u";
			4'd11: b = "l";
			4'd12: b = "l";
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[rtl/core/jsc_if.sv]
interface jsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_marker;
	modport source (output valid, text_byte, end_marker, input ready);
	modport sink (input valid, text_byte, end_marker, output ready);
endinterface

interface jsc_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic        valid_res;
	logic [4:0]  error_code;
	logic [31:0] error_line;
	logic [31:0] error_column;
	logic [31:0] range_start_line;
	logic [31:0] range_end_line;
	modport source (output valid, result_kind, valid_res, error_code, error_line,
		error_column, range_start_line, range_end_line, input ready);
	modport sink (input valid, result_kind, valid_res, error_code, error_line,
		error_column, range_start_line, range_end_line, output ready);
endinterface

[rtl/core/jsc_ram.sv]
module jsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/json_syntax_checker.sv]
// Streaming JSON syntax checker. Feed the text one byte per word on src, then a
// word with end_marker set; the block answers that word with one verdict
// (result_kind 1): valid_res, or the code, line and column of the first error.
// With report_q set, every array or object whose closing bracket sits on
// a later line than its opening one gives a range word (result_kind 0) at the
// closing bracket. One word is taken every cycle: each byte costs a single
// state decode and one access to the nesting stack, whose top entry lives in
// flops and whose lower entries sit in a RAM with a prefetched read of the
// entry just below the top. A result leaves through an output register, so
// input stalls only while that register is full and not being drained.
// Line and column counters saturate at all ones; positions are reported as
// their low 32 bits. After a verdict the checker starts a fresh text.
module json_syntax_checker #(
	parameter int MAX_DEPTH = jsc_pkg::MaxDepthDef,
	parameter int LINE_BITS = jsc_pkg::LineBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	jsc_in_if.sink    src,
	jsc_res_if.source res
);
	localparam int LVW = $clog2(MAX_DEPTH + 1);
	localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam logic [LVW-1:0] LvlMax = LVW'(MAX_DEPTH);
	localparam logic [LINE_BITS-1:0] LineSat = '1;

	// configuration
	logic report_q;

	// grammar state
	logic [4:0]           phase_q;
	logic                 key_q;
	logic [3:0]           lit_q;
	logic [2:0]           hex_q;
	logic [LVW-1:0]       level_q;
	logic [LINE_BITS-1:0] line_q, col_q;
	logic                 err_q;
	logic [4:0]           err_code_q;
	logic [LINE_BITS-1:0] err_line_q, err_col_q;

	// stack top in flops, entry below from RAM or bypass
	logic                 top_obj_q;
	logic [LINE_BITS-1:0] top_line_q;
	logic                 byp_q;
	logic [LINE_BITS:0]   byp_data_q;
	logic [LINE_BITS:0]   ram_rdata;
	logic [LINE_BITS:0]   below;

	logic accept;
	assign src.ready = !res.valid || res.ready;
	assign accept    = src.valid && src.ready;
	assign below     = byp_q ? byp_data_q : ram_rdata;

	// byte decode
	logic [7:0] b;
	logic is_ws, is_dig, is_hex;
	assign b      = src.text_byte;
	assign is_ws  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	assign is_dig = (b >= "0") && (b <= "9");
	assign is_hex = is_dig || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));

	logic [4:0] n_phase;
	logic       n_key;
	logic [3:0] n_lit;
	logic [2:0] n_hex;
	logic       fail;
	logic [4:0] fcode;
	logic       push, push_obj, pop, after, bval, closing;
	logic [2:0] hdec;

	always_comb begin
		n_phase  = phase_q;
		n_key    = key_q;
		n_lit    = lit_q;
		n_hex    = hex_q;
		fail     = 1'b0;
		fcode    = jsc_pkg::E_NONE;
		push     = 1'b0;
		push_obj = 1'b0;
		closing  = 1'b0;
		after    = 1'b0;
		bval     = 1'b0;
		hdec     = (hex_q != 3'd0) ? hex_q - 3'd1 : 3'd0;
		case (phase_q)
			jsc_pkg::P_VALUE: begin
				bval = !is_ws;
			end
			jsc_pkg::P_ARR_FIRST: begin
				if (b == "]") closing = 1'b1;
				else bval = !is_ws;
			end
			jsc_pkg::P_OBJ_FIRST, jsc_pkg::P_OBJ_KEY: begin
				if (is_ws) begin
				end else if (b == "}" && phase_q == jsc_pkg::P_OBJ_FIRST) begin
					closing = 1'b1;
				end else if (b == "\"") begin
					n_key = 1'b1;
					n_phase = jsc_pkg::P_STR;
				end else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_STRING;
				end
			end
			jsc_pkg::P_COLON: begin
				if (is_ws) begin
				end else if (b == ":") begin
					n_phase = jsc_pkg::P_VALUE;
				end else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_COLON;
				end
			end
			jsc_pkg::P_STR: begin
				if (b == "\"") n_phase = key_q ? jsc_pkg::P_COLON : jsc_pkg::P_AFTER;
				else if (b < 8'h20) begin
					fail = 1'b1;
					fcode = jsc_pkg::E_CTRL;
				end else if (b == "\\") n_phase = jsc_pkg::P_ESC;
			end
			jsc_pkg::P_ESC: begin
				if (b == "\"" || b == "\\" || b == "/" || b == "b" || b == "f" ||
					b == "n" || b == "r" || b == "t") begin
					n_phase = jsc_pkg::P_STR;
				end else if (b == "u") begin
					n_hex = 3'd4;
					n_phase = jsc_pkg::P_HEX;
				end else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_ESCAPE;
				end
			end
			jsc_pkg::P_HEX: begin
				if (!is_hex) begin
					fail = 1'b1;
					fcode = jsc_pkg::E_UNICODE;
				end else begin
					n_hex = hdec;
					if (hdec == 3'd0) n_phase = jsc_pkg::P_STR;
				end
			end
			jsc_pkg::P_LIT: begin
				if (lit_q > 4'd12 || b != jsc_pkg::lit_byte(lit_q)) begin
					fail = 1'b1;
					fcode = jsc_pkg::E_LITERAL;
				end else if (lit_q == 4'd3 || lit_q == 4'd8 || lit_q == 4'd12) begin
					n_phase = jsc_pkg::P_AFTER;
				end else begin
					n_lit = lit_q + 4'd1;
				end
			end
			jsc_pkg::P_NUM_SIGN: begin
				if (b == "0") n_phase = jsc_pkg::P_NUM_ZERO;
				else if (is_dig) n_phase = jsc_pkg::P_NUM_INT;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_DIGIT;
				end
			end
			jsc_pkg::P_NUM_ZERO, jsc_pkg::P_NUM_INT: begin
				if (is_dig) begin
					if (phase_q == jsc_pkg::P_NUM_ZERO) begin
						fail = 1'b1;
						fcode = jsc_pkg::E_LEAD_ZERO;
					end
				end else if (b == ".") n_phase = jsc_pkg::P_FRAC_FIRST;
				else if (b == "e" || b == "E") n_phase = jsc_pkg::P_EXP_FIRST;
				else after = 1'b1;
			end
			jsc_pkg::P_FRAC_FIRST: begin
				if (is_dig) n_phase = jsc_pkg::P_FRAC;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_FRAC;
				end
			end
			jsc_pkg::P_FRAC: begin
				if (is_dig) begin
				end else if (b == "e" || b == "E") n_phase = jsc_pkg::P_EXP_FIRST;
				else after = 1'b1;
			end
			jsc_pkg::P_EXP_FIRST: begin
				if (b == "+" || b == "-") n_phase = jsc_pkg::P_EXP_SIGNED;
				else if (is_dig) n_phase = jsc_pkg::P_EXP;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_EXP;
				end
			end
			jsc_pkg::P_EXP_SIGNED: begin
				if (is_dig) n_phase = jsc_pkg::P_EXP;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_EXP;
				end
			end
			jsc_pkg::P_EXP: begin
				if (!is_dig) after = 1'b1;
			end
			default: begin
				after = 1'b1;
			end
		endcase

		// start of a value
		if (bval) begin
			if (b == "{" || b == "[") begin
				if (level_q >= LvlMax) begin
					fail = 1'b1;
					fcode = jsc_pkg::E_DEEP;
				end else begin
					push = 1'b1;
					push_obj = (b == "{");
					n_phase = push_obj ? jsc_pkg::P_OBJ_FIRST : jsc_pkg::P_ARR_FIRST;
				end
			end else if (b == "\"") begin
				n_key = 1'b0;
				n_phase = jsc_pkg::P_STR;
			end else if (b == "t") begin
				n_lit = 4'd1;
				n_phase = jsc_pkg::P_LIT;
			end else if (b == "f") begin
				n_lit = 4'd5;
				n_phase = jsc_pkg::P_LIT;
			end else if (b == "n") begin
				n_lit = 4'd10;
				n_phase = jsc_pkg::P_LIT;
			end else if (b == "-") n_phase = jsc_pkg::P_NUM_SIGN;
			else if (b == "0") n_phase = jsc_pkg::P_NUM_ZERO;
			else if (is_dig) n_phase = jsc_pkg::P_NUM_INT;
			else begin
				fail = 1'b1;
				fcode = jsc_pkg::E_VALUE;
			end
		end

		// separator or closer after a value
		if (after) begin
			n_phase = jsc_pkg::P_AFTER;
			if (is_ws) begin
			end else if (level_q == '0) begin
				fail = 1'b1;
				fcode = jsc_pkg::E_TRAILING;
			end else if (top_obj_q) begin
				if (b == "}") closing = 1'b1;
				else if (b == ",") n_phase = jsc_pkg::P_OBJ_KEY;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_OBJ_SEP;
				end
			end else begin
				if (b == "]") closing = 1'b1;
				else if (b == ",") n_phase = jsc_pkg::P_VALUE;
				else begin
					fail = 1'b1;
					fcode = jsc_pkg::E_ARR_SEP;
				end
			end
		end

		if (closing) n_phase = jsc_pkg::P_AFTER;
		pop = closing && (level_q != '0);
	end

	// verdict code at end of text
	logic [4:0] end_code;
	always_comb begin
		case (phase_q)
			jsc_pkg::P_VALUE, jsc_pkg::P_ARR_FIRST:     end_code = jsc_pkg::E_VALUE;
			jsc_pkg::P_OBJ_FIRST, jsc_pkg::P_OBJ_KEY:   end_code = jsc_pkg::E_STRING;
			jsc_pkg::P_COLON:                           end_code = jsc_pkg::E_COLON;
			jsc_pkg::P_STR:                             end_code = jsc_pkg::E_UNTERM;
			jsc_pkg::P_ESC:                             end_code = jsc_pkg::E_ESC_END;
			jsc_pkg::P_HEX:                             end_code = jsc_pkg::E_UNICODE;
			jsc_pkg::P_LIT:                             end_code = jsc_pkg::E_LITERAL;
			jsc_pkg::P_NUM_SIGN:                        end_code = jsc_pkg::E_DIGIT;
			jsc_pkg::P_FRAC_FIRST:                      end_code = jsc_pkg::E_FRAC;
			jsc_pkg::P_EXP_FIRST, jsc_pkg::P_EXP_SIGNED: end_code = jsc_pkg::E_EXP;
			default: begin
				if (level_q == '0) end_code = jsc_pkg::E_NONE;
				else end_code = top_obj_q ? jsc_pkg::E_OBJ_SEP : jsc_pkg::E_ARR_SEP;
			end
		endcase
	end

	// stack RAM holds entries below the top; read always targets next level - 2
	logic            step, do_push, do_pop, flush;
	logic [LVW-1:0]  lvl_nxt;
	logic [AW-1:0]   waddr, raddr;
	logic            emit_range;

	assign flush   = accept && src.end_marker;
	assign step    = accept && !src.end_marker && !err_q;
	assign do_push = step && push;
	assign do_pop  = step && pop;
	assign emit_range = do_pop && report_q && (line_q > top_line_q);

	always_comb begin
		if (flush) lvl_nxt = '0;
		else if (do_push) lvl_nxt = level_q + LVW'(1);
		else if (do_pop) lvl_nxt = level_q - LVW'(1);
		else lvl_nxt = level_q;
	end

	assign waddr = AW'(level_q - LVW'(1));
	assign raddr = AW'(lvl_nxt - LVW'(2));

	jsc_ram #(
		.WIDTH(LINE_BITS + 1),
		.DEPTH(MAX_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (do_push && (level_q != '0)),
		.waddr(waddr),
		.wdata({top_obj_q, top_line_q}),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_q <= 1'b1;
		end else if (cfg_we) begin
			report_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= jsc_pkg::P_VALUE;
			key_q      <= 1'b0;
			lit_q      <= '0;
			hex_q      <= '0;
			level_q    <= '0;
			line_q     <= '0;
			col_q      <= '0;
			err_q      <= 1'b0;
			err_code_q <= jsc_pkg::E_NONE;
			err_line_q <= '0;
			err_col_q  <= '0;
			byp_q      <= 1'b0;
		end else if (flush) begin
			phase_q    <= jsc_pkg::P_VALUE;
			key_q      <= 1'b0;
			lit_q      <= '0;
			hex_q      <= '0;
			level_q    <= '0;
			line_q     <= '0;
			col_q      <= '0;
			err_q      <= 1'b0;
			err_code_q <= jsc_pkg::E_NONE;
			err_line_q <= '0;
			err_col_q  <= '0;
			byp_q      <= 1'b0;
		end else if (step) begin
			if (fail) begin
				// latch first error, freeze everything else
				err_q      <= 1'b1;
				err_code_q <= fcode;
				err_line_q <= line_q;
				err_col_q  <= col_q;
			end else begin
				phase_q <= n_phase;
				key_q   <= n_key;
				lit_q   <= n_lit;
				hex_q   <= n_hex;
				level_q <= lvl_nxt;
				if (do_push) byp_q <= (level_q != '0);
				else if (do_pop) byp_q <= 1'b0;
				if (b == 8'h0A) begin
					if (line_q != LineSat) line_q <= line_q + LINE_BITS'(1);
					col_q <= '0;
				end else if (col_q != LineSat) begin
					col_q <= col_q + LINE_BITS'(1);
				end
			end
		end
	end

	// stack top and bypass payload
	always_ff @(posedge clk) begin
		if (do_push && !fail) begin
			top_obj_q  <= push_obj;
			top_line_q <= line_q;
			byp_data_q <= {top_obj_q, top_line_q};
		end else if (do_pop) begin
			{top_obj_q, top_line_q} <= below;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (flush || emit_range) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			res.result_kind      <= jsc_pkg::RES_VERDICT;
			res.range_start_line <= '0;
			res.range_end_line   <= '0;
			if (err_q) begin
				res.valid_res    <= 1'b0;
				res.error_code   <= err_code_q;
				res.error_line   <= 32'(err_line_q);
				res.error_column <= 32'(err_col_q);
			end else if (end_code != jsc_pkg::E_NONE) begin
				res.valid_res    <= 1'b0;
				res.error_code   <= end_code;
				res.error_line   <= 32'(line_q);
				res.error_column <= 32'(col_q);
			end else begin
				res.valid_res    <= 1'b1;
				res.error_code   <= jsc_pkg::E_NONE;
				res.error_line   <= '0;
				res.error_column <= '0;
			end
		end else if (emit_range) begin
			res.result_kind      <= jsc_pkg::RES_RANGE;
			res.valid_res        <= 1'b0;
			res.error_code       <= jsc_pkg::E_NONE;
			res.error_line       <= '0;
			res.error_column     <= '0;
			res.range_start_line <= 32'(top_line_q);
			res.range_end_line   <= 32'(line_q);
		end
	end

	// nesting never runs past the stack
	a_depth: assert property (@(posedge clk) disable iff (!arst_n) level_q <= LvlMax)
		else $error("nesting level beyond stack depth");

	// end word always yields a verdict next cycle
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> res.valid && res.result_kind == jsc_pkg::RES_VERDICT)
		else $error("verdict missing after end word");

	// a latched error holds until the end word
	a_err_hold: assert property (@(posedge clk) disable iff (!arst_n)
		err_q && !flush |=> err_q && $stable(err_code_q))
		else $error("latched error lost");

	// the stack level only moves on an accepted word
	a_stack: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(level_q))
		else $error("stack moved without a word");
endmodule
